FILE: sv/mtig_pkg.sv
// ----------------------------------------------------------------------------
// Mesh triangle index generator package
// Shared types, mesh kind and region codes, and configuration constants.
// ----------------------------------------------------------------------------
package mtig_pkg;

    // Field widths
    localparam int unsigned C_INDEX_W = 16;
    localparam int unsigned C_COUNT_W = 8;
    localparam int unsigned C_KIND_W  = 2;
    localparam int unsigned C_CFG_W   = 8;
    localparam int unsigned C_CFG_IDX_W = 2;

    // Largest segment count that the vertex layout supports
    localparam logic [C_COUNT_W-1:0] C_MAX_SEGMENTS = 8'd255;

    // Mesh kinds
    localparam logic [C_KIND_W-1:0] C_KIND_FAN      = 2'd0;
    localparam logic [C_KIND_W-1:0] C_KIND_GRID     = 2'd1;
    localparam logic [C_KIND_W-1:0] C_KIND_CYLINDER = 2'd2;
    localparam logic [C_KIND_W-1:0] C_KIND_CONE     = 2'd3;

    // Mesh regions (cylinder: side, top cap, bottom cap; cone: tip, base)
    localparam logic [1:0] C_REGION_SIDE   = 2'd0;
    localparam logic [1:0] C_REGION_TOP    = 2'd1;
    localparam logic [1:0] C_REGION_BOTTOM = 2'd2;

    // Configuration register indexes
    localparam logic [C_CFG_IDX_W-1:0] C_REG_MESH_KIND   = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_COUNT_OUTER = 2'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_COUNT_INNER = 2'd2;

    // Sequence position within the mesh
    typedef struct packed {
        logic [1:0]           region;
        logic [C_COUNT_W-1:0] outer_pos;
        logic [C_COUNT_W-1:0] inner_pos;
        logic                 half_quad;
        logic [C_INDEX_W-1:0] row_base;
    } t_seq_state;

    // One triangle result
    typedef struct packed {
        logic [C_INDEX_W-1:0] index_first;
        logic [C_INDEX_W-1:0] index_second;
        logic [C_INDEX_W-1:0] index_third;
        logic                 last_triangle;
        logic                 bad_setup;
    } t_triangle;

    // Saturate a count to the largest supported segment count
    function automatic logic [C_COUNT_W-1:0] clamp_count(input logic [C_COUNT_W-1:0] v);
        return (v > C_MAX_SEGMENTS) ? C_MAX_SEGMENTS : v;
    endfunction

endpackage

FILE: sv/mtig_step.sv
// ----------------------------------------------------------------------------
// Mesh triangle index step
// Computes the indices of the current triangle and the next sequence
// position from the configuration and the present position.
// ----------------------------------------------------------------------------
module mtig_step (
    input  logic [1:0]          i_mesh_kind,
    input  logic [7:0]          i_count_outer,
    input  logic [7:0]          i_count_inner,
    input  logic                i_restart,
    input  mtig_pkg::t_seq_state i_state,
    output mtig_pkg::t_seq_state o_state,
    output mtig_pkg::t_triangle  o_tri
);
    import mtig_pkg::*;

    t_seq_state           cur;
    t_seq_state           nxt;
    t_triangle            tri_out;
    logic [C_COUNT_W-1:0] seg;
    logic [C_INDEX_W-1:0] seg16;
    logic [C_COUNT_W-1:0] pos;
    logic [C_INDEX_W-1:0] pos16;
    logic [C_COUNT_W:0]   pos_inc;
    logic                 pos_end;
    logic [C_INDEX_W-1:0] wrap16;
    logic [C_COUNT_W-1:0] rows;
    logic [C_COUNT_W-1:0] cols;
    logic [C_INDEX_W-1:0] cols16;
    logic [C_COUNT_W:0]   inner_inc;
    logic [C_INDEX_W-1:0] grid_cur;
    logic [C_INDEX_W-1:0] grid_nxt;
    logic [C_INDEX_W-1:0] seg_x2;
    logic [C_INDEX_W-1:0] seg_x3;
    logic [C_INDEX_W-1:0] seg_x4;

    // Segment count, position and its wrapped successor; grid operands
    always_comb begin
        cur     = i_restart ? '0 : i_state;
        seg     = clamp_count(i_count_outer);
        seg16   = {8'd0, seg};
        pos     = cur.outer_pos;
        pos16   = {8'd0, pos};
        pos_inc = {1'b0, pos} + 9'd1;
        pos_end = (pos_inc >= {1'b0, seg});
        wrap16  = pos_end ? '0 : {7'd0, pos_inc};
        seg_x2  = seg16 << 1;
        seg_x3  = (seg16 << 1) + seg16;
        seg_x4  = seg16 << 2;

        rows      = (seg == '0) ? 8'd1 : seg;
        cols      = (clamp_count(i_count_inner) == '0) ? 8'd1 : clamp_count(i_count_inner);
        cols16    = {8'd0, cols};
        inner_inc = {1'b0, cur.inner_pos} + 9'd1;
        grid_cur  = cur.row_base + {8'd0, cur.inner_pos};
        grid_nxt  = grid_cur + cols16 + 16'd1;
    end

    // Triangle indices and next position for each mesh kind
    always_comb begin
        nxt     = cur;
        tri_out = '0;
        if ((i_mesh_kind != C_KIND_GRID) && (seg < 8'd3)) begin
            tri_out.last_triangle = 1'b1;
            tri_out.bad_setup     = 1'b1;
        end else begin
            unique case (i_mesh_kind)
                C_KIND_FAN: begin
                    tri_out.index_first   = '0;
                    tri_out.index_second  = pos16 + 16'd1;
                    tri_out.index_third   = wrap16 + 16'd1;
                    tri_out.last_triangle = pos_end;
                    nxt.outer_pos         = pos_inc[C_COUNT_W-1:0];
                end
                C_KIND_GRID: begin
                    if (!cur.half_quad) begin
                        tri_out.index_first  = grid_cur;
                        tri_out.index_second = grid_nxt;
                        tri_out.index_third  = grid_cur + 16'd1;
                        nxt.half_quad        = 1'b1;
                    end else begin
                        tri_out.index_first  = grid_cur + 16'd1;
                        tri_out.index_second = grid_nxt;
                        tri_out.index_third  = grid_nxt + 16'd1;
                        nxt.half_quad        = 1'b0;
                        if (inner_inc >= {1'b0, cols}) begin
                            nxt.inner_pos         = '0;
                            nxt.row_base          = cur.row_base + cols16 + 16'd1;
                            nxt.outer_pos         = pos_inc[C_COUNT_W-1:0];
                            tri_out.last_triangle = (pos_inc >= {1'b0, rows});
                        end else begin
                            nxt.inner_pos = inner_inc[C_COUNT_W-1:0];
                        end
                    end
                end
                C_KIND_CYLINDER: begin
                    priority if (cur.region == C_REGION_SIDE) begin
                        if (!cur.half_quad) begin
                            tri_out.index_first  = pos16;
                            tri_out.index_second = pos16 + 16'd1;
                            tri_out.index_third  = pos16 + seg16 + 16'd2;
                            nxt.half_quad        = 1'b1;
                        end else begin
                            tri_out.index_first  = pos16 + seg16 + 16'd2;
                            tri_out.index_second = pos16 + seg16 + 16'd1;
                            tri_out.index_third  = pos16;
                            nxt.half_quad        = 1'b0;
                            if (pos_end) begin
                                nxt.outer_pos = '0;
                                nxt.region    = C_REGION_TOP;
                            end else begin
                                nxt.outer_pos = pos_inc[C_COUNT_W-1:0];
                            end
                        end
                    end else if (cur.region == C_REGION_TOP) begin
                        tri_out.index_first  = seg_x3 + 16'd2;
                        tri_out.index_second = seg_x2 + 16'd2 + wrap16;
                        tri_out.index_third  = seg_x2 + 16'd2 + pos16;
                        if (pos_end) begin
                            nxt.outer_pos = '0;
                            nxt.region    = C_REGION_BOTTOM;
                        end else begin
                            nxt.outer_pos = pos_inc[C_COUNT_W-1:0];
                        end
                    end else begin
                        tri_out.index_first   = seg_x4 + 16'd3;
                        tri_out.index_second  = seg_x3 + 16'd3 + pos16;
                        tri_out.index_third   = seg_x3 + 16'd3 + wrap16;
                        tri_out.last_triangle = pos_end;
                        nxt.outer_pos         = pos_inc[C_COUNT_W-1:0];
                    end
                end
                C_KIND_CONE: begin
                    if (cur.region == C_REGION_SIDE) begin
                        tri_out.index_first  = seg16;
                        tri_out.index_second = pos16;
                        tri_out.index_third  = wrap16;
                        if (pos_end) begin
                            nxt.outer_pos = '0;
                            nxt.region    = C_REGION_TOP;
                        end else begin
                            nxt.outer_pos = pos_inc[C_COUNT_W-1:0];
                        end
                    end else begin
                        tri_out.index_first   = seg_x2 + 16'd1;
                        tri_out.index_second  = seg16 + 16'd1 + wrap16;
                        tri_out.index_third   = seg16 + 16'd1 + pos16;
                        tri_out.last_triangle = pos_end;
                        nxt.outer_pos         = pos_inc[C_COUNT_W-1:0];
                    end
                end
                default: begin
                    nxt = cur;
                end
            endcase
        end

        // The final triangle, or a bad setup, returns to the start
        if (tri_out.last_triangle) begin
            nxt = '0;
        end
    end

    assign o_state = nxt;
    assign o_tri   = tri_out;

endmodule

FILE: sv/mesh_triangle_index_generator.sv
// Each accepted result is registered in the output buffer. Throughput: one triangle
// per cycle while o_in_stall is low; the next position is computed from the
// registered position within the same cycle, so requests can follow back to back.
// A two-entry output buffer lets input continue while one result waits downstream.
// Reset (synchronous, active low) selects a 1 x 1 grid, clears the sequence
// position and empties the output buffer.
// ----------------------------------------------------------------------------
// Mesh triangle index generator
// Emits the vertex indices of one triangle per request for a polygon fan,
// grid, capped cylinder or cone, restarting after the final triangle.
// ----------------------------------------------------------------------------
module mesh_triangle_index_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_restart,
    // Triangle channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_index_first,
    output logic [15:0] o_index_second,
    output logic [15:0] o_index_third,
    output logic        o_last_triangle,
    output logic        o_bad_setup
);
    import mtig_pkg::*;

    logic [C_KIND_W-1:0]  r_mesh_kind;
    logic [C_COUNT_W-1:0] r_count_outer;
    logic [C_COUNT_W-1:0] r_count_inner;
    t_seq_state           r_seq;
    t_seq_state           n_seq;
    t_triangle            n_tri;
    logic                 r_out_valid;
    t_triangle            r_out;
    logic                 r_skid_valid;
    t_triangle            r_skid;
    logic                 in_fire;
    logic                 out_fire;
    logic                 cfg_hit;

    assign in_fire  = i_in_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_out_stall;
    assign cfg_hit  = i_cfg_wr_en && ((i_cfg_index == C_REG_MESH_KIND) ||
                                      (i_cfg_index == C_REG_COUNT_OUTER) ||
                                      (i_cfg_index == C_REG_COUNT_INNER));

    // Triangle computation
    mtig_step u_step (
        .i_mesh_kind   (r_mesh_kind),
        .i_count_outer (r_count_outer),
        .i_count_inner (r_count_inner),
        .i_restart     (i_restart),
        .i_state       (r_seq),
        .o_state       (n_seq),
        .o_tri         (n_tri)
    );

    // Configuration registers and sequence position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mesh_kind   <= C_KIND_GRID;
            r_count_outer <= 8'd1;
            r_count_inner <= 8'd1;
            r_seq         <= '0;
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                C_REG_MESH_KIND:   r_mesh_kind   <= i_cfg_data[C_KIND_W-1:0];
                C_REG_COUNT_OUTER: r_count_outer <= i_cfg_data;
                C_REG_COUNT_INNER: r_count_inner <= i_cfg_data;
                default:           r_mesh_kind   <= r_mesh_kind;
            endcase
            r_seq <= '0;
        end else if (in_fire) begin
            r_seq <= n_seq;
        end
    end

    // Output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output buffer payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= n_tri;
            end else begin
                r_out <= n_tri;
            end
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_index_first   = r_out.index_first;
    assign o_index_second  = r_out.index_second;
    assign o_index_third   = r_out.index_third;
    assign o_last_triangle = r_out.last_triangle;
    assign o_bad_setup     = r_out.bad_setup;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Mesh triangle index generator testbench
// Drives triangle requests through the valid/stall request channel under
// random idling, writes mesh configurations between phases, and checks every
// triangle on the output channel against an in-order expectation store that a
// local sequence predictor fills for each accepted request.
// ----------------------------------------------------------------------------
module tb_top;
    import mtig_pkg::*;

    // Scoreboard: predicts the triangle for each request and checks results
    class triangle_scoreboard;
        logic [C_KIND_W-1:0]  kind;
        logic [C_COUNT_W-1:0] outer_cfg;
        logic [C_COUNT_W-1:0] inner_cfg;
        logic [1:0]           region;
        int unsigned          seg_pos;
        int unsigned          col_pos;
        bit                   second_half;
        int unsigned          row_start;
        t_triangle            expected_q[$];
        int unsigned          mismatches;
        int unsigned          triangles_checked;
        int unsigned          meshes_closed;
        int unsigned          setup_errors;

        function new();
            kind      = C_KIND_GRID;
            outer_cfg = 8'd1;
            inner_cfg = 8'd1;
            restart_sequence();
        endfunction

        function void restart_sequence();
            region      = C_REGION_SIDE;
            seg_pos     = 0;
            col_pos     = 0;
            second_half = 1'b0;
            row_start   = 0;
        endfunction

        // A write to any known register returns the sequence to its start.
        function void write_register(logic [C_CFG_IDX_W-1:0] idx, logic [C_CFG_W-1:0] data);
            case (idx)
                C_REG_MESH_KIND:   kind = data[C_KIND_W-1:0];
                C_REG_COUNT_OUTER: outer_cfg = data;
                C_REG_COUNT_INNER: inner_cfg = data;
                default: return;
            endcase
            restart_sequence();
        endfunction

        function int unsigned wrap_inc(int unsigned pos, int unsigned limit);
            return (pos + 1 >= limit) ? 0 : pos + 1;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Work out the triangle that one accepted request produces.
        function void note_request(logic restart_bit);
            t_triangle   tri_exp;
            int unsigned segs;
            int unsigned rows;
            int unsigned cols;
            int unsigned cur;
            int unsigned nxt;
            int unsigned a;
            int unsigned b;
            int unsigned c;
            int unsigned i;
            bit          closes_mesh;

            segs = (outer_cfg > C_MAX_SEGMENTS) ? C_MAX_SEGMENTS : outer_cfg;
            a = 0;
            b = 0;
            c = 0;
            closes_mesh = 1'b0;
            if (restart_bit) restart_sequence();

            // Fan, cylinder and cone need at least three segments.
            if (kind != C_KIND_GRID && segs < 3) begin
                restart_sequence();
                tri_exp = '{16'd0, 16'd0, 16'd0, 1'b1, 1'b1};
                expected_q.push_back(tri_exp);
                return;
            end

            i = seg_pos;
            case (kind)
                C_KIND_FAN: begin
                    a = 0;
                    b = i + 1;
                    c = wrap_inc(i, segs) + 1;
                    closes_mesh = (i + 1 >= segs);
                    seg_pos = i + 1;
                end
                C_KIND_GRID: begin
                    rows = (segs == 0) ? 1 : segs;
                    cols = (inner_cfg > C_MAX_SEGMENTS) ? C_MAX_SEGMENTS : inner_cfg;
                    if (cols == 0) cols = 1;
                    cur = row_start + col_pos;
                    nxt = cur + cols + 1;
                    if (!second_half) begin
                        a = cur;
                        b = nxt;
                        c = cur + 1;
                        second_half = 1'b1;
                    end else begin
                        a = cur + 1;
                        b = nxt;
                        c = nxt + 1;
                        second_half = 1'b0;
                        col_pos = col_pos + 1;
                        if (col_pos >= cols) begin
                            col_pos = 0;
                            row_start = (row_start + cols + 1) & 32'hFFFF;
                            seg_pos = seg_pos + 1;
                            closes_mesh = (seg_pos >= rows);
                        end
                    end
                end
                C_KIND_CYLINDER: begin
                    if (region == C_REGION_SIDE) begin
                        if (!second_half) begin
                            a = i;
                            b = i + 1;
                            c = i + segs + 2;
                            second_half = 1'b1;
                        end else begin
                            a = i + segs + 2;
                            b = i + segs + 1;
                            c = i;
                            second_half = 1'b0;
                            seg_pos = i + 1;
                            if (seg_pos >= segs) begin
                                seg_pos = 0;
                                region = C_REGION_TOP;
                            end
                        end
                    end else if (region == C_REGION_TOP) begin
                        a = 3 * segs + 2;
                        b = 2 * segs + 2 + wrap_inc(i, segs);
                        c = 2 * segs + 2 + i;
                        seg_pos = i + 1;
                        if (seg_pos >= segs) begin
                            seg_pos = 0;
                            region = C_REGION_BOTTOM;
                        end
                    end else begin
                        a = 4 * segs + 3;
                        b = 3 * segs + 3 + i;
                        c = 3 * segs + 3 + wrap_inc(i, segs);
                        closes_mesh = (i + 1 >= segs);
                        seg_pos = i + 1;
                    end
                end
                default: begin
                    // Cone: tip fan, then base cap
                    if (region == C_REGION_SIDE) begin
                        a = segs;
                        b = i;
                        c = wrap_inc(i, segs);
                        seg_pos = i + 1;
                        if (seg_pos >= segs) begin
                            seg_pos = 0;
                            region = C_REGION_TOP;
                        end
                    end else begin
                        a = 2 * segs + 1;
                        b = segs + 1 + wrap_inc(i, segs);
                        c = segs + 1 + i;
                        closes_mesh = (i + 1 >= segs);
                        seg_pos = i + 1;
                    end
                end
            endcase

            if (closes_mesh) restart_sequence();
            tri_exp = '{a[15:0], b[15:0], c[15:0], closes_mesh, 1'b0};
            expected_q.push_back(tri_exp);
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned got_val);
            if (exp_val != got_val) begin
                $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
                mismatches++;
            end
        endfunction

        // Compare one output transaction with the oldest expectation.
        function void check_triangle(t_triangle got);
            t_triangle want;
            if (expected_q.size() == 0) begin
                $error("triangle: none expected, actual %h", got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            triangles_checked++;
            if (want.last_triangle) meshes_closed++;
            if (want.bad_setup) setup_errors++;
            compare_field("index_first", want.index_first, got.index_first);
            compare_field("index_second", want.index_second, got.index_second);
            compare_field("index_third", want.index_third, got.index_third);
            compare_field("last_triangle", want.last_triangle, got.last_triangle);
            compare_field("bad_setup", want.bad_setup, got.bad_setup);
        endfunction
    endclass

    localparam int unsigned RANDOM_REQUESTS = 600;
    localparam int unsigned HOLD_CYCLES     = 60;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [C_CFG_IDX_W-1:0] i_cfg_index = C_REG_MESH_KIND;
    logic [C_CFG_W-1:0]     i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_restart = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [15:0]            o_index_first;
    logic [15:0]            o_index_second;
    logic [15:0]            o_index_third;
    logic                   o_last_triangle;
    logic                   o_bad_setup;

    triangle_scoreboard sb = new();

    int unsigned requests_sent = 0;
    int unsigned requests_accepted = 0;
    int unsigned restarts_sent = 0;
    int unsigned settings_used = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    mesh_triangle_index_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_index_first   (o_index_first),
        .o_index_second  (o_index_second),
        .o_index_third   (o_index_third),
        .o_last_triangle (o_last_triangle),
        .o_bad_setup     (o_bad_setup)
    );

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Monitor both channels at each rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(i_restart);
                requests_accepted <= requests_accepted + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_triangle({o_index_first, o_index_second, o_index_third,
                                   o_last_triangle, o_bad_setup});
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a quiet window with none.
    always @(posedge i_clk) begin
        if (!hold_done && requests_accepted >= 200) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (requests_accepted >= 320 && requests_accepted < 440) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 6);
        end
    end

    // One register write; the caller lowers the write enable afterwards.
    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx, input logic [C_CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_register(idx, data);
    endtask

    task automatic configure(input logic [C_KIND_W-1:0] kind, input logic [7:0] outer,
                             input logic [7:0] inner);
        write_reg(C_REG_MESH_KIND, {6'd0, kind});
        write_reg(C_REG_COUNT_OUTER, outer);
        write_reg(C_REG_COUNT_INNER, inner);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Offer one request transaction and wait until it is taken.
    task automatic send_request(input logic restart_bit);
        int unsigned gap;
        bit          quiet;
        quiet = (requests_sent >= 320 && requests_sent < 440);
        if (!quiet && $urandom_range(99) < 4) begin
            gap = $urandom_range(1, 2);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart_bit;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
        if (restart_bit) restarts_sent++;
    endtask

    // Drain all expected triangles so the block is idle for the next setting.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic send_run(input int unsigned count);
        repeat (count) send_request(1'b0);
    endtask

    // Stimulus
    initial begin
        int unsigned phase_items;
        int unsigned pick;
        logic [7:0]  outer;
        logic [7:0]  inner;
        logic [1:0]  kind;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting is a 1 x 1 grid: two triangles, then it wraps.
        send_run(3);
        settle();
        // Zero grid counts behave as one.
        configure(C_KIND_GRID, 8'd0, 8'd0);
        send_run(2);
        settle();
        // Too few segments for fan, cylinder and cone.
        configure(C_KIND_FAN, 8'd0, 8'd0);
        send_run(1);
        settle();
        configure(C_KIND_CYLINDER, 8'd2, 8'd0);
        send_run(1);
        settle();
        configure(C_KIND_CONE, 8'd1, 8'd255);
        send_run(1);
        settle();
        // Small fan through its wrap, then a restart.
        configure(C_KIND_FAN, 8'd3, 8'd0);
        send_run(3);
        send_request(1'b1);
        settle();
        // Full cone: tip fan and base cap.
        configure(C_KIND_CONE, 8'd3, 8'd0);
        send_run(6);
        settle();
        // Largest sizes with a restart part way in.
        configure(C_KIND_CYLINDER, 8'd255, 8'd255);
        send_run(2);
        send_request(1'b1);
        settle();
        configure(C_KIND_GRID, 8'd255, 8'd255);
        send_run(2);
        send_request(1'b1);
        settle();

        // Random phases: mostly small meshes run through several wraps.
        while (requests_sent < 24 + RANDOM_REQUESTS) begin
            kind = 2'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 70) begin
                outer = 8'($urandom_range(6));
                inner = 8'($urandom_range(6));
            end else if (pick < 85) begin
                outer = 8'($urandom_range(255));
                inner = 8'($urandom_range(255));
            end else begin
                outer = ($urandom_range(1) != 0) ? 8'd255 : 8'($urandom_range(3));
                inner = ($urandom_range(1) != 0) ? 8'd255 : 8'($urandom_range(1));
            end
            // Not every register is rewritten; upper kind bits carry noise.
            if ($urandom_range(3) != 0)
                write_reg(C_REG_MESH_KIND, {6'($urandom_range(63)), kind});
            if ($urandom_range(3) != 0) write_reg(C_REG_COUNT_OUTER, outer);
            if ($urandom_range(3) != 0) write_reg(C_REG_COUNT_INNER, inner);
            i_cfg_wr_en <= 1'b0;
            settings_used++;
            phase_items = $urandom_range(10, 60);
            repeat (phase_items) send_request($urandom_range(99) < 4);
            settle();
        end

        $display("Run covered %0d requests (%0d restarts) over %0d register settings.",
                 requests_sent, restarts_sent, settings_used);
        $display("Checked %0d triangles: %0d mesh ends, %0d setup errors flagged.",
                 sb.triangles_checked, sb.meshes_closed, sb.setup_errors);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
